>>> rtl/sha256_pkg.sv
// Shared types, constants and the rotate helper for the SHA-256 hasher.
package sha256_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic       load_word;   // write push_data at fill position
        logic       start_comp;  // copy hash into working words
        logic       round;       // run one round
        logic       finish_comp; // add working words into hash
        logic       reinit;      // reset hash, length, fill
        logic       add_len;     // add len_inc to bit length
        logic [5:0] round_idx;
        logic [2:0] out_idx;
    } dp_cmd_t;

    localparam int unsigned DIGEST_WORDS = 8;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/sha256_datapath.sv
// SHA-256 datapath: block window, working words, hash words, bit length.
module sha256_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::dp_cmd_t   cmd,
    input  logic [31:0]           push_data,
    input  logic [5:0]            len_inc,
    output logic [3:0]            fill_pos,
    output logic [63:0]           bit_len,
    output logic [31:0]           digest_word
);
    import sha256_pkg::*;

    logic [31:0] win_reg [16];
    logic [31:0] wk_reg [8];
    logic [31:0] wk_next [8];
    logic [31:0] hash_reg [8];
    logic [63:0] len_reg;
    logic [3:0]  fill_reg;
    logic [31:0] w_cur, wa, wb, sa, sb, s0, s1, ch, mj, t1, t2;
    logic [3:0]  t4;

    assign t4 = cmd.round_idx[3:0];
    assign wa = win_reg[t4 + 4'd1];
    assign wb = win_reg[t4 + 4'd14];
    assign sa = ror(wa, 7) ^ ror(wa, 18) ^ (wa >> 3);
    assign sb = ror(wb, 17) ^ ror(wb, 19) ^ (wb >> 10);
    assign w_cur = (cmd.round_idx < 6'd16) ? win_reg[t4]
                 : win_reg[t4] + sa + win_reg[t4 + 4'd9] + sb;

    always_comb
    begin
        s1 = ror(wk_reg[4], 6) ^ ror(wk_reg[4], 11) ^ ror(wk_reg[4], 25);
        ch = (wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]);
        t1 = wk_reg[7] + s1 + ch + K_TAB[cmd.round_idx] + w_cur;
        s0 = ror(wk_reg[0], 2) ^ ror(wk_reg[0], 13) ^ ror(wk_reg[0], 22);
        mj = (wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]);
        t2 = s0 + mj;
        wk_next[0] = t1 + t2;
        wk_next[1] = wk_reg[0];
        wk_next[2] = wk_reg[1];
        wk_next[3] = wk_reg[2];
        wk_next[4] = wk_reg[3] + t1;
        wk_next[5] = wk_reg[4];
        wk_next[6] = wk_reg[5];
        wk_next[7] = wk_reg[6];
    end

    // window has no reset: every entry is written before it is read
    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            win_reg[fill_reg] <= push_data;
        end
        else if (cmd.round)
        begin
            win_reg[t4] <= w_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wk_reg[i]   <= '0;
                hash_reg[i] <= H_INIT[i];
            end
            len_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cmd.load_word)
                fill_reg <= fill_reg + 4'd1;
            if (cmd.add_len)
                len_reg <= len_reg + {58'd0, len_inc};
            for (int i = 0; i < 8; i++)
            begin
                if (cmd.start_comp)
                    wk_reg[i] <= hash_reg[i];
                else if (cmd.round)
                    wk_reg[i] <= wk_next[i];
                if (cmd.finish_comp)
                    hash_reg[i] <= hash_reg[i] + wk_reg[i];
                else if (cmd.reinit)
                    hash_reg[i] <= H_INIT[i];
            end
            if (cmd.reinit)
            begin
                len_reg  <= '0;
                fill_reg <= '0;
            end
        end
    end

    assign fill_pos    = fill_reg;
    assign bit_len     = len_reg;
    assign digest_word = hash_reg[cmd.out_idx];

endmodule

>>> rtl/sha256_ctrl.sv
// SHA-256 controller: word intake, padding, round sequencing, digest output.
module sha256_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::in_word_t  in_word,
    input  logic                  in_fire,
    output logic                  in_rdy,
    input  logic                  out_rdy,
    output logic                  out_vld,
    output logic [2:0]            out_idx,
    input  logic [3:0]            fill_pos,
    input  logic [63:0]           bit_len,
    output sha256_pkg::dp_cmd_t   cmd,
    output logic [31:0]           push_data,
    output logic [5:0]            len_inc
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1; // push second word (pad after full last)
    localparam logic [2:0] ST_ZERO = 3'd2; // zero fill / length words
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] oidx_reg, oidx_next;
    logic       pad_reg, pad_next;   // padding in progress
    logic       need_reg, need_next; // padding word still to push
    logic       spill_reg, spill_next; // pad byte landed too late for the length
    logic       done_reg, done_next; // block being compressed carries the length
    logic [2:0] cnt;
    logic [31:0] mask, tail;
    logic       wrap;

    always_comb
    begin
        cnt = (in_word.byte_count > 3'd4 || !in_word.last_word) ? 3'd4 : in_word.byte_count;
        case (cnt)
            3'd0:    mask = 32'h0;
            3'd1:    mask = 32'hff000000;
            3'd2:    mask = 32'hffff0000;
            3'd3:    mask = 32'hffffff00;
            default: mask = 32'hffffffff;
        endcase
        case (cnt)
            3'd0:    tail = {PAD_BYTE, 24'd0};
            3'd1:    tail = {8'd0, PAD_BYTE, 16'd0};
            3'd2:    tail = {16'd0, PAD_BYTE, 8'd0};
            3'd3:    tail = {24'd0, PAD_BYTE};
            default: tail = 32'd0;
        endcase
    end

    assign wrap = (fill_pos == 4'd15);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        pad_next   = pad_reg;
        need_next  = need_reg;
        spill_next = spill_reg;
        cmd        = '0;
        push_data  = '0;
        len_inc    = {cnt, 3'd0};
        in_rdy     = (state_reg == ST_IDLE);
        out_vld    = (state_reg == ST_OUT);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_word = 1'b1;
                    cmd.add_len   = 1'b1;
                    push_data     = (in_word.data_word & mask) | tail;
                    pad_next      = in_word.last_word;
                    need_next     = in_word.last_word && (cnt == 3'd4);
                    spill_next    = in_word.last_word && (cnt != 3'd4) &&
                                    (fill_pos >= 4'd14);
                    if (wrap)
                        state_next = ST_INIT;
                    else if (in_word.last_word)
                        state_next = (cnt == 3'd4) ? ST_PUSH : ST_ZERO;
                end
            end
            ST_PUSH:
            begin
                cmd.load_word = 1'b1;
                push_data     = {PAD_BYTE, 24'd0};
                need_next     = 1'b0;
                spill_next    = (fill_pos >= 4'd14);
                state_next    = wrap ? ST_INIT : ST_ZERO;
            end
            ST_ZERO:
            begin
                cmd.load_word = 1'b1;
                // length words only in the block that has room for them
                if (!spill_reg && fill_pos == 4'd14)
                    push_data = bit_len[63:32];
                else if (!spill_reg && fill_pos == 4'd15)
                    push_data = bit_len[31:0];
                if (wrap)
                begin
                    state_next = ST_INIT;
                    if (!spill_reg)
                        pad_next = 1'b0;
                end
            end
            ST_INIT:
            begin
                cmd.start_comp = 1'b1;
                rnd_next       = '0;
                spill_next     = 1'b0;
                state_next     = ST_RND;
            end
            ST_RND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.finish_comp = 1'b1;
                oidx_next       = '0;
                // after the length block, emit; else continue padding or idle
                if (done_reg)
                    state_next = ST_OUT;
                else if (need_reg)
                    state_next = ST_PUSH;
                else if (pad_reg)
                    state_next = ST_ZERO;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_rdy)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.round_idx = rnd_reg;
        cmd.out_idx   = oidx_reg;
    end

    always_comb
    begin
        done_next = done_reg;
        if (state_reg == ST_ZERO && wrap && !spill_reg)
            done_next = 1'b1;
        else if (state_reg == ST_ADD)
            done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            pad_reg   <= 1'b0;
            need_reg  <= 1'b0;
            spill_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            pad_reg   <= pad_next;
            need_reg  <= need_next;
            spill_reg <= spill_next;
            done_reg  <= done_next;
        end
    end

    assign out_idx = oidx_reg;

    a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == ST_IDLE)
        else $error("word accepted while busy");
    a_rounds_64: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> $past(rnd_reg) == 6'd63)
        else $error("compression ended early");
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld && out_rdy && oidx_reg != 3'd7) |=> oidx_reg == $past(oidx_reg) + 3'd1)
        else $error("digest index skipped");

endmodule

>>> rtl/sha256_message_hasher_top.sv
// Top level of the SHA-256 message hasher.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------
//  in      | in_valid / in_ready         | in_data  (data_word, byte_count, last_word)
//  out     | out_valid / out_ready       | out_data (digest_word, word_index, last_of_digest)
//
// A word is taken whenever the hasher is idle; every sixteenth window word
// starts a compression (hash copied into the working words, one round per
// cycle on the shared round unit, then the working words added into the
// hash), and no word is taken until it is done. The last word adds padding
// pushes (one per cycle), one or two compressions, then eight digest words.
// Reset loads the initial hash values. Output stalls hold the digest word.
module sha256_message_hasher_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sha256_pkg::in_word_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sha256_pkg::out_word_t  out_data
);
    import sha256_pkg::*;

    dp_cmd_t     cmd;
    logic [31:0] push_data;
    logic [5:0]  len_inc;
    logic [3:0]  fill_pos;
    logic [63:0] bit_len;
    logic [31:0] digest;
    logic [2:0]  out_idx;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_data),
        .in_fire   (in_valid && in_ready),
        .in_rdy    (in_ready),
        .out_rdy   (out_ready),
        .out_vld   (out_valid),
        .out_idx   (out_idx),
        .fill_pos  (fill_pos),
        .bit_len   (bit_len),
        .cmd       (cmd),
        .push_data (push_data),
        .len_inc   (len_inc)
    );

    sha256_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .push_data   (push_data),
        .len_inc     (len_inc),
        .fill_pos    (fill_pos),
        .bit_len     (bit_len),
        .digest_word (digest)
    );

    // digest word reads straight from the hash registers, stable while stalled
    assign out_data.digest_word    = digest;
    assign out_data.word_index     = out_idx;
    assign out_data.last_of_digest = (out_idx == 3'd7);

endmodule

>>> bench/tb.sv
// Self-checking testbench for the SHA-256 message hasher.
`timescale 1ns / 1ps

module tb;
    import sha256_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    sha256_message_hasher_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Predictor state: running hash, block window, message bit length.
    logic [31:0] hash_acc [8];
    logic [31:0] block_buf [16];
    logic [63:0] msg_bits;
    int          fill_idx;

    out_word_t   digest_queue[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 38;
    int          recv_idle_pct = 73;
    bit          hold_recv = 1'b0;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of block_buf into hash_acc.
    task automatic compress_block_buf();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w[t] = block_buf[t];
            else
                w[t] = w[t-16] + w[t-7]
                     + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                     + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        {a, b, c, d, e, f, g, h} = {hash_acc[0], hash_acc[1], hash_acc[2], hash_acc[3],
                                    hash_acc[4], hash_acc[5], hash_acc[6], hash_acc[7]};
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
        hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
    endtask

    task automatic append_block_word(logic [31:0] wd);
        block_buf[fill_idx] = wd;
        fill_idx = (fill_idx + 1) % 16;
        if (fill_idx == 0)
            compress_block_buf();
    endtask

    task automatic restart_digest();
        for (int i = 0; i < 8; i++)
            hash_acc[i] = H_INIT[i];
        msg_bits = '0;
        fill_idx = 0;
    endtask

    // Folds one accepted message word into the running hash; on a last word
    // pads, finishes and queues the eight digest words.
    task automatic absorb_word(in_word_t wd);
        int          nbytes;
        logic [31:0] keep;
        out_word_t   dw;
        nbytes = (wd.byte_count > 4 || !wd.last_word) ? 4 : wd.byte_count;
        if (!wd.last_word)
        begin
            msg_bits += 32;
            append_block_word(wd.data_word);
            return;
        end
        msg_bits += 8 * nbytes;
        if (nbytes == 4)
        begin
            append_block_word(wd.data_word);
            append_block_word({PAD_BYTE, 24'h0});
        end
        else
        begin
            keep = (nbytes == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nbytes));
            append_block_word((wd.data_word & keep) | (32'(PAD_BYTE) << (24 - 8 * nbytes)));
        end
        while (fill_idx != 14)
            append_block_word(32'h0);
        append_block_word(msg_bits[63:32]);
        append_block_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++)
        begin
            dw = '{hash_acc[i], 3'(i), i == 7};
            digest_queue = {digest_queue, dw};
        end
        restart_digest();
    endtask

    // Offer one word and hold it until taken.
    task automatic send_word(in_word_t wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= wd;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_word(wd);
    endtask

    // Random message: mostly short, sometimes spanning a few blocks.
    task automatic send_random_message();
        int len;
        in_word_t wd;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
        for (int i = 0; i < len; i++)
        begin
            wd = '{$urandom, 3'($urandom_range(7)), 1'b0};
            send_word(wd);
        end
        wd = '{$urandom, 3'($urandom_range(7)), 1'b1};
        send_word(wd);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(posedge clk)
    begin
        if (hold_recv)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Digest checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_queue.size() == 0)
            begin
                $error("digest word with nothing expected: %h", out_data.digest_word);
                fail_count++;
            end
            else
            begin
                out_word_t exp_w;
                exp_w = digest_queue.pop_front();
                if (out_data.digest_word !== exp_w.digest_word)
                begin
                    $error("digest_word expected %h actual %h",
                           exp_w.digest_word, out_data.digest_word);
                    fail_count++;
                end
                if (out_data.word_index !== exp_w.word_index)
                begin
                    $error("word_index expected %0d actual %0d",
                           exp_w.word_index, out_data.word_index);
                    fail_count++;
                end
                if (out_data.last_of_digest !== exp_w.last_of_digest)
                begin
                    $error("last_of_digest expected %0d actual %0d",
                           exp_w.last_of_digest, out_data.last_of_digest);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering words.
    task automatic hold_receiver();
        hold_recv = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_recv = 1'b0;
    endtask

    // Directed rows. Expected digest given where it is well known.
    typedef struct {
        in_word_t    wd;
        bit          known;
        logic [31:0] d0;
        logic [31:0] d7;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        // empty message
        '{'{32'h0, 3'd0, 1'b1}, 1, 32'he3b0c442, 32'h7852b855},
        // "abc"
        '{'{32'h61626300, 3'd3, 1'b1}, 1, 32'hba7816bf, 32'hf20015ad},
        // "abc" with junk in the unused byte
        '{'{32'h616263ff, 3'd3, 1'b1}, 1, 32'hba7816bf, 32'hf20015ad},
        // empty tail with garbage data
        '{'{32'hffffffff, 3'd0, 1'b1}, 1, 32'he3b0c442, 32'h7852b855},
        '{'{32'hffffffff, 3'd1, 1'b1}, 0, 0, 0},
        '{'{32'h00000000, 3'd2, 1'b1}, 0, 0, 0},
        '{'{32'hffffffff, 3'd4, 1'b1}, 0, 0, 0},
        // counts above four act as four
        '{'{32'h12345678, 3'd5, 1'b1}, 0, 0, 0},
        '{'{32'h12345678, 3'd7, 1'b1}, 0, 0, 0},
        // short count on a non-last word still takes four bytes
        '{'{32'hdeadbeef, 3'd0, 1'b0}, 0, 0, 0},
        '{'{32'hcafef00d, 3'd2, 1'b0}, 0, 0, 0},
        '{'{32'h0, 3'd6, 1'b1}, 0, 0, 0}
    };

    initial
    begin
        restart_digest();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            send_word(dir_rows[r].wd);
            if (dir_rows[r].known && digest_queue.size() >= 8)
            begin
                digest_queue[digest_queue.size() - 8].digest_word = dir_rows[r].d0;
                digest_queue[digest_queue.size() - 1].digest_word = dir_rows[r].d7;
            end
        end
        // fourteen and fifteen full words: padding spills into an extra block
        for (int n = 14; n <= 15; n++)
        begin
            for (int i = 0; i < n; i++)
                send_word('{32'hffffffff, 3'd4, 1'b0});
            send_word('{32'h0, 3'd0, 1'b1});
        end

        // three phases: idle rates swapped, then none and a receiver hold-off
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 38 : 0;
            if (ph == 2)
                fork
                    hold_receiver();
                join_none
            for (int m = 0; m < 13; m++)
                send_random_message();
        end
        in_valid <= 1'b0;

        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
